// ===== hw/rtl/edc_pkg.sv =====
`timescale 1ns / 1ps

package edc_pkg;

  // Cost cells are 16 bits and saturate at all ones
  localparam int COST_BITS = 16;
  localparam logic [COST_BITS-1:0] COST_MAX = '1;

  // Register reset value
  localparam logic [1:0] SUB_COST_RESET = 2'd2;

  // Input item kinds, carried on s_tuser
  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_QUERY  = 2'd1,
    FUNC_FINISH = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  // Wavefront token handed from one cell to the next
  typedef struct packed {
    logic                 valid;
    logic                 clip;
    logic [COST_BITS-1:0] left;   // new cost of the upstream column
    logic [COST_BITS-1:0] diag;   // previous cost of the upstream column
  } link_t;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic       restart;
    logic       load;
    logic       active;
    logic [1:0] sub_cost;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/edit_distance_engine_top.sv =====
`timescale 1ns / 1ps
// Channel   | Direction | Payload
// ----------+-----------+-------------------------------------------------
// s_t*      | in        | tuser: func[1:0]; tdata: symbol
// m_t*      | out       | tdata: distance[15:0]; tuser: saturated
// cfg_*     | in        | wdata: substitution_cost[1:0]
//
// Query symbols are taken one per cycle; each one walks the cell chain, one
// column per cycle; its distance is registered when the token leaves the chain.
// Load, clear and finish wait until the last query token has left the chain.
// Finish also waits for a free output register.
// rst is synchronous: costs return to 0..MAX_REF_LEN, reference is emptied.

module edit_distance_engine_top
  import edc_pkg::*;
#(
  parameter int MAX_REF_LEN = 64,
  parameter int SYMBOL_BITS = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_wdata,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [((SYMBOL_BITS+7)/8)*8-1:0]   s_tdata,   // [SYMBOL_BITS-1:0] symbol
  input  logic [1:0]                         s_tuser,   // [1:0] func
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [COST_BITS-1:0]               m_tdata,   // [15:0] distance
  output logic                               m_tuser    // [0] saturated
);

  localparam int RLW       = $clog2(MAX_REF_LEN + 1);
  localparam int DRAIN_LEN = MAX_REF_LEN + 1;
  localparam int DW        = $clog2(DRAIN_LEN + 1);

  logic [1:0]           sub_cost;
  logic [RLW-1:0]       ref_len;
  logic [RLW-1:0]       ref_len_next;
  logic [COST_BITS-1:0] qlen;
  logic [DW-1:0]        drain;
  logic [COST_BITS-1:0] distance;
  logic                 clip_acc;

  func_t func;
  logic  accept;
  logic  idle;
  logic  query_acc;
  logic  load_acc;
  logic  finish_acc;
  logic  clear_acc;
  logic  restart;

  link_t                  links [MAX_REF_LEN+1];
  logic [SYMBOL_BITS-1:0] syms  [MAX_REF_LEN+1];
  cell_ctrl_t             ctrls [MAX_REF_LEN+1];
  link_t                  tail;

  // Handshake decode
  assign func       = func_t'(s_tuser);
  assign idle       = (drain == '0);
  always_comb begin
    case (func)
      FUNC_QUERY:  s_tready = 1'b1;
      FUNC_FINISH: s_tready = idle && (!m_tvalid || m_tready);
      default:     s_tready = idle;
    endcase
  end
  assign accept     = s_tvalid && s_tready;
  assign query_acc  = accept && (func == FUNC_QUERY);
  assign load_acc   = accept && (func == FUNC_LOAD);
  assign finish_acc = accept && (func == FUNC_FINISH);
  assign clear_acc  = accept && (func == FUNC_CLEAR);
  assign restart    = load_acc || finish_acc || clear_acc;

  // Reference length after this transaction
  always_comb begin
    ref_len_next = ref_len;
    if (clear_acc) begin
      ref_len_next = '0;
    end else if (load_acc && (ref_len < RLW'(MAX_REF_LEN))) begin
      ref_len_next = ref_len + RLW'(1);
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      sub_cost <= SUB_COST_RESET;
    end else if (cfg_we) begin
      sub_cost <= cfg_wdata;
    end
  end

  // Column zero: reference length, query length, drain count and token injection
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_len        <= '0;
      qlen           <= '0;
      drain          <= '0;
      links[0].valid <= 1'b0;
    end else begin
      ref_len        <= ref_len_next;
      links[0].valid <= query_acc;
      if (query_acc) begin
        drain <= DW'(DRAIN_LEN);
      end else if (!idle) begin
        drain <= drain - DW'(1);
      end
      if (restart) begin
        qlen <= '0;
      end else if (query_acc && (qlen != COST_MAX)) begin
        qlen <= qlen + COST_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    syms[0]       <= s_tdata[SYMBOL_BITS-1:0];
    links[0].diag <= qlen;
    links[0].clip <= (qlen == COST_MAX);
    links[0].left <= (qlen == COST_MAX) ? qlen : qlen + COST_BITS'(1);
  end

  // Chain of DP columns
  for (genvar j = 1; j <= MAX_REF_LEN; j++) begin : g_cell
    assign ctrls[j].restart  = restart;
    assign ctrls[j].load     = load_acc && (ref_len == RLW'(j - 1));
    assign ctrls[j].active   = (RLW'(j) <= ref_len);
    assign ctrls[j].sub_cost = sub_cost;

    edc_cell #(
      .INDEX       (j),
      .SYMBOL_BITS (SYMBOL_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrls[j]),
      .load_sym (s_tdata[SYMBOL_BITS-1:0]),
      .link_in  (links[j-1]),
      .sym_in   (syms[j-1]),
      .link_out (links[j]),
      .sym_out  (syms[j])
    );
  end

  // Column zero has no cell; tie its control off
  assign ctrls[0] = '0;

  // Tail: the last column's cost is the distance so far
  assign tail = links[MAX_REF_LEN];

  always_ff @(posedge clk) begin
    if (rst) begin
      distance <= '0;
      clip_acc <= 1'b0;
    end else if (restart) begin
      distance <= COST_BITS'(ref_len_next);
      clip_acc <= 1'b0;
    end else if (tail.valid) begin
      distance <= tail.left;
      clip_acc <= clip_acc | tail.clip;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish_acc) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_acc) begin
      m_tdata <= distance;
      m_tuser <= clip_acc;
    end
  end

  // A token never reaches the tail after the drain count has run out
  a_tail_in_drain: assert property (@(posedge clk) disable iff (rst)
    tail.valid |-> (drain != '0))
    else $error("token left chain after drain window");

  // A freshly injected token has the full drain window ahead
  a_inject_drain: assert property (@(posedge clk) disable iff (rst)
    links[0].valid |-> (drain == DW'(DRAIN_LEN)))
    else $error("drain not armed on query");

  // Restart clears the query state
  a_restart_clear: assert property (@(posedge clk) disable iff (rst)
    restart |=> (qlen == '0) && !clip_acc && (distance == COST_BITS'(ref_len)))
    else $error("query restart incomplete");

  // Reference length stays within the chain
  a_ref_len: assert property (@(posedge clk) disable iff (rst)
    ref_len <= RLW'(MAX_REF_LEN))
    else $error("reference length overflow");

endmodule

// ===== hw/rtl/edc_cell.sv =====
`timescale 1ns / 1ps

module edc_cell
  import edc_pkg::*;
#(
  parameter int INDEX       = 1,
  parameter int SYMBOL_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cell_ctrl_t             ctrl,
  input  logic [SYMBOL_BITS-1:0] load_sym,
  input  link_t                  link_in,
  input  logic [SYMBOL_BITS-1:0] sym_in,
  output link_t                  link_out,
  output logic [SYMBOL_BITS-1:0] sym_out
);

  // Reference symbol held by this column, and its current row cost
  logic [SYMBOL_BITS-1:0] ref_sym;
  logic [COST_BITS-1:0]   cost;

  logic [COST_BITS-1:0] min_ul;
  logic [COST_BITS:0]   indel;
  logic [COST_BITS:0]   subst;
  logic [COST_BITS:0]   best;
  logic                 clipped;
  logic [COST_BITS-1:0] result;

  // One DP cell: min(up, left) + 1 against diag + mismatch cost
  always_comb begin
    min_ul  = (cost < link_in.left) ? cost : link_in.left;
    indel   = {1'b0, min_ul} + (COST_BITS+1)'(1);
    subst   = {1'b0, link_in.diag} +
              ((ref_sym == sym_in) ? '0 : (COST_BITS+1)'(ctrl.sub_cost));
    best    = (subst < indel) ? subst : indel;
    clipped = best[COST_BITS];
    result  = clipped ? COST_MAX : best[COST_BITS-1:0];
  end

  // Reference storage, written once per load
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      ref_sym <= load_sym;
    end
  end

  // Row cost and outgoing token
  always_ff @(posedge clk) begin
    if (rst) begin
      cost           <= COST_BITS'(INDEX);
      link_out.valid <= 1'b0;
    end else begin
      link_out.valid <= link_in.valid;
      if (ctrl.restart) begin
        cost <= COST_BITS'(INDEX);
      end else if (link_in.valid && ctrl.active) begin
        cost <= result;
      end
    end
  end

  always_ff @(posedge clk) begin
    sym_out <= sym_in;
    if (ctrl.active) begin
      link_out.left <= result;
      link_out.diag <= cost;
      link_out.clip <= link_in.clip | clipped;
    end else begin
      // Columns past the reference end pass the token unchanged
      link_out.left <= link_in.left;
      link_out.diag <= link_in.diag;
      link_out.clip <= link_in.clip;
    end
  end

endmodule
